>>> sv/scl_pkg.sv
// ============================================================================
// scl_pkg: shared types and functions of the sensor command line parser
// Holds the item structs, the result kinds, the per-line parse state and the
// byte-level token functions used by the parser and its classifier.
// ============================================================================
package scl_pkg;

    localparam int LINE_CAPACITY_DEF = 64;

    // Keyword candidates: 0 SENSE, 1 FAULT, 2 PRESS, 3 DOOR,
    // 4 the timeout keyword, 5 OPEN, 6 CLOSED.
    localparam int KW_COUNT = 7;
    localparam int KW_BYTES = 14;

    localparam logic [KW_BYTES*8-1:0] KW_STR [KW_COUNT] = '{
        "SENSE", "FAULT", "PRESS", "DOOR", {"SENSOR_", "TIMEOUT"}, "OPEN", "CLOSED"
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd5, 4'd5, 4'd5, 4'd4, 4'd14, 4'd4, 4'd6
    };

    // Number flag bit positions.
    localparam int NF_STARTED = 0;
    localparam int NF_NEG     = 1;
    localparam int NF_DIGIT   = 2;
    localparam int NF_BAD     = 3;

    localparam logic [7:0] PRESSURE_MAX = 8'd120;

    typedef enum logic [2:0] {
        KIND_IGNORED      = 3'd0,
        KIND_PRESSURE     = 3'd1,
        KIND_BAD_PRESSURE = 3'd2,
        KIND_DOOR_OPEN    = 3'd3,
        KIND_DOOR_CLOSED  = 3'd4,
        KIND_BAD_DOOR     = 3'd5,
        KIND_TIMEOUT      = 3'd6
    } t_kind;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       has_char;
        logic       line_end;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [6:0] pressure;
        logic       door_is_closed;
    } t_out_item;

    // Parse state of one line. Match bits 0..6 are the live candidates of
    // the open token, bits 8..14 record finished keyword matches, and bit 15
    // marks a valid number in the third token.
    typedef struct packed {
        logic [2:0]  token_index;
        logic        in_token;
        logic [15:0] match_flags;
        logic [6:0]  token_position;
        logic [7:0]  number_value;
        logic [3:0]  number_flags;
        logic [7:0]  third_value;
    } t_parse;

    localparam t_parse PARSE_RESET = '{
        token_index:    3'd0,
        in_token:       1'b0,
        match_flags:    16'h007F,
        token_position: 7'd0,
        number_value:   8'd0,
        number_flags:   4'd0,
        third_value:    8'd0
    };

    function automatic logic f_is_white(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Folds one token byte into the parse state.
    function automatic t_parse f_token_char(input t_parse p, input logic [7:0] c);
        t_parse      q;
        logic [3:0]  ci;
        logic [7:0]  kc;
        logic [11:0] t;
        q = p;
        if (!q.in_token) begin
            q.in_token       = 1'b1;
            q.token_position = 7'd0;
            q.match_flags    = {q.match_flags[15:8], 8'h7F};
            q.number_value   = 8'd0;
            q.number_flags   = 4'd0;
        end
        for (int k = 0; k < KW_COUNT; k++) begin
            ci = KW_LEN[k] - 4'd1 - q.token_position[3:0];
            kc = KW_STR[k][{ci, 3'b000} +: 8];
            if (q.match_flags[k] &&
                !(q.token_position < {3'b000, KW_LEN[k]} && c == kc)) begin
                q.match_flags[k] = 1'b0;
            end
        end
        if (!q.number_flags[NF_BAD]) begin
            if (c >= 8'h30 && c <= 8'h39) begin
                t = {4'd0, q.number_value} * 12'd10 + {4'd0, c - 8'h30};
                q.number_value = (t > 12'd255) ? 8'd255 : t[7:0];
                q.number_flags[NF_STARTED] = 1'b1;
                q.number_flags[NF_DIGIT]   = 1'b1;
            end else if (!q.number_flags[NF_STARTED]) begin
                if (c == 8'h2B || c == 8'h2D) begin
                    q.number_flags[NF_STARTED] = 1'b1;
                    if (c == 8'h2D) begin
                        q.number_flags[NF_NEG] = 1'b1;
                    end
                end else if (!f_is_white(c)) begin
                    q.number_flags[NF_BAD] = 1'b1;
                end
            end else begin
                q.number_flags[NF_BAD] = 1'b1;
            end
        end
        if (q.token_position < 7'd127) begin
            q.token_position = q.token_position + 7'd1;
        end
        return q;
    endfunction

    // Closes the open token, recording keyword and number matches by slot.
    function automatic t_parse f_end_token(input t_parse p);
        t_parse                q;
        logic [KW_COUNT-1:0]   m;
        logic                  num_ok;
        q = p;
        m = '0;
        if (q.in_token) begin
            q.in_token = 1'b0;
            for (int k = 0; k < KW_COUNT; k++) begin
                m[k] = q.match_flags[k] && (q.token_position == {3'b000, KW_LEN[k]});
            end
            num_ok = q.number_flags[NF_DIGIT] && !q.number_flags[NF_BAD] &&
                     (q.number_value <= PRESSURE_MAX) &&
                     (!q.number_flags[NF_NEG] || q.number_value == 8'd0);
            case (q.token_index)
                3'd0: q.match_flags[9:8]   = q.match_flags[9:8] | m[1:0];
                3'd1: q.match_flags[12:10] = q.match_flags[12:10] | m[4:2];
                3'd2: begin
                    q.match_flags[14:13] = q.match_flags[14:13] | m[6:5];
                    q.match_flags[15]    = q.match_flags[15] | num_ok;
                    q.third_value        = q.number_value;
                end
                default: ;
            endcase
            if (q.token_index < 3'd7) begin
                q.token_index = q.token_index + 3'd1;
            end
        end
        return q;
    endfunction

endpackage

>>> sv/scl_classify.sv
// ============================================================================
// scl_classify: closes the last token of a line and names the command
// Takes the captured parse state of a finished line and forms its result.
// ============================================================================
module scl_classify
    import scl_pkg::*;
(
    input  t_parse    i_line,
    output t_out_item o_result
);

    t_parse      fin;
    logic [15:0] fl;
    logic [2:0]  n;

    always_comb begin
        fin = f_end_token(i_line);
        fl  = fin.match_flags;
        n   = fin.token_index;
        o_result.kind           = KIND_IGNORED;
        o_result.pressure       = 7'd0;
        o_result.door_is_closed = 1'b0;
        if (n >= 3'd2 && fl[8] && fl[10]) begin
            if (n == 3'd3 && fl[15]) begin
                o_result.kind     = KIND_PRESSURE;
                o_result.pressure = fin.third_value[6:0];
            end else begin
                o_result.kind = KIND_BAD_PRESSURE;
            end
        end else if (n == 3'd3 && fl[8] && fl[11]) begin
            if (fl[13]) begin
                o_result.kind = KIND_DOOR_OPEN;
            end else if (fl[14]) begin
                o_result.kind           = KIND_DOOR_CLOSED;
                o_result.door_is_closed = 1'b1;
            end else begin
                o_result.kind = KIND_BAD_DOOR;
            end
        end else if (n == 3'd2 && fl[9] && fl[12]) begin
            o_result.kind = KIND_TIMEOUT;
        end
    end

endmodule

>>> sv/sensor_command_line_parser_unit.sv
// ============================================================================
// sensor_command_line_parser_unit: byte-serial sensor command line parser
// Parses one text line per result: pressure, door and fault commands.
// ============================================================================
// Usage: the sender presents one item per cycle on the input channel, each
// carrying one character, a flag saying whether the character is real, and
// a flag marking the last item of the line. Only the last item of a line
// produces a result item on the output channel; all others are absorbed.
// Each accepted character updates small token match, number and position
// registers, so the block takes one item every cycle while not stalled.
// When the last item is accepted, the parse state of the line is captured
// in a line register; the classifier's answer, which closes the final
// token, then loads the output register as soon as that register is free.
// The parse state is cleared in the accepting edge, so the first character
// of the next line may follow at once.
// When the receiver stalls, a held result keeps the output register and a
// second finished line waits in the line register; only when both are full
// does the input stall rise. Reset clears all parse state and empties both
// stages; no result is pending afterwards.
module sensor_command_line_parser_unit
    import scl_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    localparam int CNT_W = $clog2(LINE_CAPACITY);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LINE_CAPACITY - 1);

    // Parse state: the running copy and the copy taken after the last
    // non-space byte, which lets trailing white space drop out.
    t_parse           r_live, n_live;
    t_parse           r_snap, n_snap;
    logic [CNT_W-1:0] r_char_count, n_char_count;
    logic             r_pending_space, n_pending_space;
    logic             r_seen_text, n_seen_text;

    // Line register between the parser and the classifier.
    t_parse    r_line;
    logic      r_line_valid;
    t_out_item line_result;

    t_out_item r_out;
    logic      r_out_valid;

    logic   in_accept;
    logic   out_load;
    t_parse line_state;

    // The output register loads whenever it is empty or being emptied.
    assign out_load   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_line_valid && !out_load;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Per-byte update of the parse state.
    always_comb begin
        n_live          = r_live;
        n_snap          = r_snap;
        n_char_count    = r_char_count;
        n_pending_space = r_pending_space;
        n_seen_text     = r_seen_text;
        if (i_in_item.has_char && r_char_count < CNT_LIMIT) begin
            if (i_in_item.char_byte == 8'h00) begin
                // A zero byte ends the text; the rest of the line is ignored.
                n_char_count = CNT_LIMIT;
            end else begin
                n_char_count = r_char_count + CNT_W'(1);
                if (f_is_white(i_in_item.char_byte)) begin
                    if (r_seen_text) begin
                        n_pending_space = 1'b1;
                        // Only space and tab split tokens; other white space
                        // stays inside the token.
                        if (i_in_item.char_byte == 8'h20 || i_in_item.char_byte == 8'h09) begin
                            n_live = f_end_token(r_live);
                        end else begin
                            n_live = f_token_char(r_live, i_in_item.char_byte);
                        end
                    end
                end else begin
                    n_seen_text     = 1'b1;
                    n_live          = f_token_char(r_live, i_in_item.char_byte);
                    n_snap          = n_live;
                    n_pending_space = 1'b0;
                end
            end
        end
        line_state = n_pending_space ? n_snap : n_live;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live          <= PARSE_RESET;
            r_snap          <= PARSE_RESET;
            r_char_count    <= '0;
            r_pending_space <= 1'b0;
            r_seen_text     <= 1'b0;
        end else if (in_accept) begin
            if (i_in_item.line_end) begin
                r_live          <= PARSE_RESET;
                r_snap          <= PARSE_RESET;
                r_char_count    <= '0;
                r_pending_space <= 1'b0;
                r_seen_text     <= 1'b0;
            end else begin
                r_live          <= n_live;
                r_snap          <= n_snap;
                r_char_count    <= n_char_count;
                r_pending_space <= n_pending_space;
                r_seen_text     <= n_seen_text;
            end
        end
    end

    // Line register: filled by a line end, emptied into the output stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_valid <= 1'b0;
        end else if (in_accept && i_in_item.line_end) begin
            r_line_valid <= 1'b1;
        end else if (out_load) begin
            r_line_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_in_item.line_end) begin
            r_line <= line_state;
        end
    end

    scl_classify u_classify (
        .i_line   (r_line),
        .o_result (line_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_line_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_line_valid) begin
            r_out <= line_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // The input only stalls when a finished line is waiting behind a held result.
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_line_valid && r_out_valid))
        else $error("input stalled without a waiting line");

    // An accepted line end always leaves a finished line in the line register.
    a_line_captured : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_item.line_end) |=> r_line_valid)
        else $error("line end not captured");

    // A reported pressure is in range, and only pressure results carry one.
    a_pressure_field : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_item.kind == KIND_PRESSURE)
            ? (o_out_item.pressure <= PRESSURE_MAX[6:0]) : (o_out_item.pressure == 7'd0)))
        else $error("pressure field inconsistent with kind");

    // The door flag is set exactly for a closed-door result.
    a_door_field : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.door_is_closed == (o_out_item.kind == KIND_DOOR_CLOSED)))
        else $error("door flag inconsistent with kind");

    // The character count never runs past the line capacity.
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_char_count <= CNT_LIMIT)
        else $error("character count beyond line capacity");

endmodule

>>> verif/tb_sensor_command_line_parser_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_sensor_command_line_parser_unit: self-checking bench of the line parser
// Feeds whole text lines to the parser one byte item at a time. A scoreboard
// keeps its own byte-level model of the tokenizer and the command classifier,
// predicts the one result of every line and checks each result field by field
// while both channels idle and stall at random.
// ============================================================================
module tb_sensor_command_line_parser_unit
    import scl_pkg::*;
();

    localparam int LINE_CAP     = LINE_CAPACITY_DEF;
    localparam int ITEM_TARGET  = 1400;
    localparam int CALM_FROM    = 1150;  // no idling on either side after this
    localparam int STALL_LIMIT  = 2000;  // cycles without any handshake
    localparam int DRAIN_CYCLES = 10;

    // The fault keyword that follows FAULT.
    localparam string TIMEOUT_WORD = {"SENSOR_", "TIMEOUT"};

    // Characters the parser treats specially.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Number flag bits.
    localparam int NUM_STARTED = 0;
    localparam int NUM_NEG     = 1;
    localparam int NUM_DIGIT   = 2;
    localparam int NUM_BAD     = 3;

    // Keywords, in the order of their candidate bits. A finished match of
    // keyword k is kept at bit DONE_BASE + k, and bit NUM_OK_BIT marks a
    // valid pressure number in the third word.
    typedef enum int {
        KW_SENSE   = 0,
        KW_FAULT   = 1,
        KW_PRESS   = 2,
        KW_DOOR    = 3,
        KW_TIMEOUT = 4,
        KW_OPEN    = 5,
        KW_CLOSED  = 6
    } t_keyword;
    localparam int KW_NUM     = 7;
    localparam int DONE_BASE  = 8;
    localparam int NUM_OK_BIT = 15;

    typedef struct packed {
        logic [2:0]  word_idx;
        logic        in_word;
        logic [15:0] flags;
        logic [6:0]  word_pos;
        logic [7:0]  num_val;
        logic [3:0]  num_fl;
        logic [7:0]  third_val;
    } t_line_state;

    // Holds the parser's state as seen from outside and the results of the
    // lines that have been accepted but not yet answered.
    class line_scoreboard;
        t_out_item   line_verdicts[$];
        t_line_state live_st;
        t_line_state snap_st;
        int          char_cnt;
        bit          pending_ws;
        bit          seen_text;
        int          errors;

        function new();
            errors = 0;
            clear_line();
        endfunction

        function void clear_line();
            live_st       = '0;
            live_st.flags = 16'h007F;
            snap_st       = live_st;
            char_cnt      = 0;
            pending_ws    = 0;
            seen_text     = 0;
        endfunction

        function int pending();
            return line_verdicts.size();
        endfunction

        function bit is_space(logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function string keyword_text(int k);
            case (k)
                KW_SENSE:   return "SENSE";
                KW_FAULT:   return "FAULT";
                KW_PRESS:   return "PRESS";
                KW_DOOR:    return "DOOR";
                KW_TIMEOUT: return TIMEOUT_WORD;
                KW_OPEN:    return "OPEN";
                default:    return "CLOSED";
            endcase
        endfunction

        // One byte of a word: narrows the keyword candidates and runs the
        // saturating decimal accumulator.
        function t_line_state fold_byte(t_line_state s, logic [7:0] c);
            string word;
            int    t;
            if (!s.in_word) begin
                s.in_word     = 1'b1;
                s.word_pos    = '0;
                s.flags[7:0]  = 8'h7F;
                s.num_val     = '0;
                s.num_fl      = '0;
            end
            for (int k = 0; k < KW_NUM; k++) begin
                word = keyword_text(k);
                if (s.flags[k] && !(s.word_pos < word.len() && c == word[s.word_pos])) begin
                    s.flags[k] = 1'b0;
                end
            end
            if (!s.num_fl[NUM_BAD]) begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    t = int'(s.num_val) * 10 + int'(c - CH_ZERO);
                    s.num_val = (t > 255) ? 8'd255 : t[7:0];
                    s.num_fl[NUM_STARTED] = 1'b1;
                    s.num_fl[NUM_DIGIT]   = 1'b1;
                end else if (!s.num_fl[NUM_STARTED]) begin
                    if (c == CH_PLUS || c == CH_MINUS) begin
                        s.num_fl[NUM_STARTED] = 1'b1;
                        if (c == CH_MINUS) begin
                            s.num_fl[NUM_NEG] = 1'b1;
                        end
                    end else if (!is_space(c)) begin
                        s.num_fl[NUM_BAD] = 1'b1;
                    end
                end else begin
                    s.num_fl[NUM_BAD] = 1'b1;
                end
            end
            if (s.word_pos < 7'd127) begin
                s.word_pos++;
            end
            return s;
        endfunction

        // Ends the open word and records which keyword it was, by position.
        function t_line_state close_word(t_line_state s);
            logic [KW_NUM-1:0] hit;
            bit                num_ok;
            int                slot;
            string             word;
            if (!s.in_word) begin
                return s;
            end
            s.in_word = 1'b0;
            for (int k = 0; k < KW_NUM; k++) begin
                word   = keyword_text(k);
                hit[k] = s.flags[k] && (s.word_pos == word.len());
            end
            num_ok = s.num_fl[NUM_DIGIT] && !s.num_fl[NUM_BAD] && s.num_val <= 8'd120 &&
                     (!s.num_fl[NUM_NEG] || s.num_val == 8'd0);
            for (int k = 0; k < KW_NUM; k++) begin
                // SENSE and FAULT lead a line, PRESS, DOOR and the timeout
                // keyword come second, OPEN and CLOSED third.
                slot = (k < KW_PRESS) ? 0 : ((k < KW_OPEN) ? 1 : 2);
                if (hit[k] && slot == s.word_idx) begin
                    s.flags[DONE_BASE + k] = 1'b1;
                end
            end
            if (s.word_idx == 3'd2) begin
                if (num_ok) begin
                    s.flags[NUM_OK_BIT] = 1'b1;
                end
                s.third_val = s.num_val;
            end
            if (s.word_idx < 3'd7) begin
                s.word_idx++;
            end
            return s;
        endfunction

        function t_out_item judge_line(t_line_state f);
            t_out_item   v;
            logic [15:0] fl;
            fl = f.flags;
            v  = '{kind: KIND_IGNORED, pressure: '0, door_is_closed: 1'b0};
            if (f.word_idx >= 3'd2 && fl[DONE_BASE + KW_SENSE] && fl[DONE_BASE + KW_PRESS]) begin
                if (f.word_idx == 3'd3 && fl[NUM_OK_BIT]) begin
                    v.kind     = KIND_PRESSURE;
                    v.pressure = f.third_val[6:0];
                end else begin
                    v.kind = KIND_BAD_PRESSURE;
                end
            end else if (f.word_idx == 3'd3 && fl[DONE_BASE + KW_SENSE] &&
                         fl[DONE_BASE + KW_DOOR]) begin
                if (fl[DONE_BASE + KW_OPEN]) begin
                    v.kind = KIND_DOOR_OPEN;
                end else if (fl[DONE_BASE + KW_CLOSED]) begin
                    v.kind           = KIND_DOOR_CLOSED;
                    v.door_is_closed = 1'b1;
                end else begin
                    v.kind = KIND_BAD_DOOR;
                end
            end else if (f.word_idx == 3'd2 && fl[DONE_BASE + KW_FAULT] &&
                         fl[DONE_BASE + KW_TIMEOUT]) begin
                v.kind = KIND_TIMEOUT;
            end
            return v;
        endfunction

        // Called for every accepted input item.
        function void note_item(t_in_item it);
            logic [7:0] c;
            c = it.char_byte;
            if (it.has_char && char_cnt < LINE_CAP - 1) begin
                if (c == CH_NUL) begin
                    // A zero byte ends the text of the line.
                    char_cnt = LINE_CAP - 1;
                end else begin
                    char_cnt++;
                    if (is_space(c)) begin
                        if (seen_text) begin
                            pending_ws = 1'b1;
                            if (c == CH_SPACE || c == CH_TAB) begin
                                live_st = close_word(live_st);
                            end else begin
                                live_st = fold_byte(live_st, c);
                            end
                        end
                    end else begin
                        seen_text  = 1'b1;
                        live_st    = fold_byte(live_st, c);
                        snap_st    = live_st;
                        pending_ws = 1'b0;
                    end
                end
            end
            if (it.line_end) begin
                // Trailing white space is dropped by judging the state as it
                // stood after the last non-space byte.
                line_verdicts.push_back(judge_line(close_word(pending_ws ? snap_st : live_st)));
                clear_line();
            end
        endfunction

        function void check_verdict(t_out_item got);
            t_out_item want;
            if (line_verdicts.size() == 0) begin
                $error("result with no line pending: kind %0d pressure %0d closed %0d",
                       got.kind, got.pressure, got.door_is_closed);
                errors++;
                return;
            end
            want = line_verdicts.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                errors++;
            end
            if (got.pressure !== want.pressure) begin
                $error("pressure: expected %0d, got %0d", want.pressure, got.pressure);
                errors++;
            end
            if (got.door_is_closed !== want.door_is_closed) begin
                $error("door_is_closed: expected %0d, got %0d",
                       want.door_is_closed, got.door_is_closed);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_item  i_in_item;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;
    logic      i_out_stall;

    line_scoreboard board;
    logic [7:0]     line_bytes[$];   // text of the line being built
    int             items_sent;
    int             quiet_cycles;
    bit             calm_tail;       // set for the last part of the run

    sensor_command_line_parser_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Handshake monitor and watchdog. Both channels are sampled at the rising
    // edge; every input and output changes only through nonblocking updates
    // at that edge, so the values read here are the ones the block saw.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                board.note_item(i_in_item);
            end
            if (o_out_valid && !i_out_stall) begin
                board.check_verdict(o_out_item);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Receiver: switches at random between stall and ready bursts, with
    // longer ready stretches now and then, and stays ready in the tail.
    initial begin
        int  span;
        bit  hold;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            span = $urandom_range(1, 19);
            hold = !calm_tail && ($urandom_range(0, 2) == 0);
            if (!calm_tail && $urandom_range(0, 9) == 0) begin
                span = $urandom_range(40, 150);
                hold = 1'b0;
            end
            i_out_stall <= hold;
            repeat (span) @(posedge i_clk);
        end
    end

    // Presents one item and returns at the edge that accepted it. Within this task,
    // valid is lowered only for an idle burst, so back-to-back items keep it high.
    task automatic send_item(input t_in_item it);
        if (!calm_tail && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // Sends the bytes of line_bytes. The line ends either on its last byte
    // or on an extra item with no character. Items without a character are
    // slipped in mid-line now and then.
    task automatic send_line(input bit end_on_char);
        t_in_item it;
        int       last;
        last = line_bytes.size() - 1;
        foreach (line_bytes[i]) begin
            if ($urandom_range(0, 24) == 0) begin
                it = '{char_byte: 8'($urandom), has_char: 1'b0, line_end: 1'b0};
                send_item(it);
            end
            it = '{char_byte: line_bytes[i], has_char: 1'b1,
                   line_end: end_on_char && (i == last)};
            send_item(it);
        end
        if (!end_on_char || line_bytes.size() == 0) begin
            it = '{char_byte: 8'($urandom), has_char: 1'b0, line_end: 1'b1};
            send_item(it);
        end
    endtask

    // Holds the sender back until every pending line has been answered.
    task automatic wait_all_answered();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (board.pending() != 0);
        @(posedge i_clk);
    endtask

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            line_bytes.push_back(s[i]);
        end
    endfunction

    function automatic void push_blanks(input int n);
        repeat (n) line_bytes.push_back(CH_SPACE);
    endfunction

    // One to three separators, spaces and tabs mixed.
    function automatic void push_gap();
        repeat ($urandom_range(1, 3)) begin
            line_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        end
    endfunction

    // A short run of any white space, for the ends of a line.
    function automatic void push_white();
        repeat ($urandom_range(1, 3)) begin
            line_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(9, 13)));
        end
    endfunction

    // Pressure values: mostly in range, and the malformed and out-of-range
    // forms the number rules know about.
    function automatic string number_text();
        int v;
        v = $urandom_range(0, 120);
        case ($urandom_range(0, 13))
            0:       return $sformatf("-%0d", v);
            1:       return $sformatf("+%0d", v);
            2:       return "-0";
            3:       return $sformatf("%0d", $urandom_range(121, 300));
            4:       return $sformatf("%0d", $urandom_range(1000, 99999));
            5:       return $sformatf("%0dx", v);
            6: begin
                if ($urandom_range(0, 1) != 0) begin
                    return "+";
                end
                return "--3";
            end
            7:       return $sformatf("\r%0d", v);
            8:       return $sformatf("00%0d", v);
            9:       return $sformatf("%0d+", v);
            default: return $sformatf("%0d", v);
        endcase
    endfunction

    function automatic string any_word();
        case ($urandom_range(0, 14))
            0:       return "SENSE";
            1:       return "PRESS";
            2:       return "DOOR";
            3:       return "OPEN";
            4:       return "CLOSED";
            5:       return "FAULT";
            6:       return TIMEOUT_WORD;
            7:       return "SENS";
            8:       return "SENSES";
            9:       return "sense";
            10:      return "OPENED";
            11:      return "SENSOR_TIMEOU";
            12:      return "CLOSE";
            default: return number_text();
        endcase
    endfunction

    // Builds a random line: mostly well-formed commands with random values
    // and spacing, the rest broken commands and raw noise.
    function automatic void build_random_line();
        int form;
        int at;
        line_bytes.delete();
        if ($urandom_range(0, 4) == 0) begin
            push_white();
        end
        form = $urandom_range(0, 99);
        if (form < 35) begin
            push_text("SENSE");
            push_gap();
            push_text("PRESS");
            if ($urandom_range(0, 15) != 0) begin
                push_gap();
                push_text(number_text());
            end
        end else if (form < 55) begin
            push_text("SENSE");
            push_gap();
            push_text("DOOR");
            if ($urandom_range(0, 15) != 0) begin
                push_gap();
                case ($urandom_range(0, 4))
                    0, 1:    push_text("OPEN");
                    2, 3:    push_text("CLOSED");
                    default: push_text(any_word());
                endcase
            end
        end else if (form < 65) begin
            push_text("FAULT");
            push_gap();
            push_text(TIMEOUT_WORD);
        end else if (form < 82) begin
            repeat ($urandom_range(1, 4)) begin
                push_text(any_word());
                push_gap();
            end
        end else begin
            repeat ($urandom_range(0, 24)) line_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0) begin
            push_gap();
            push_text(any_word());
        end
        if ($urandom_range(0, 4) == 0) begin
            push_white();
        end
        if (line_bytes.size() > 0 && $urandom_range(0, 11) == 0) begin
            line_bytes[$urandom_range(0, line_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 29) == 0) begin
            line_bytes.insert($urandom_range(0, line_bytes.size()), CH_NUL);
        end
        // Now and then a line runs past the capacity. Where the padding
        // lands decides whether the command is cut, kept or lost entirely.
        if ($urandom_range(0, 29) == 0) begin
            at = $urandom_range(0, line_bytes.size());
            repeat ($urandom_range(40, 70)) line_bytes.insert(at, CH_SPACE);
            push_text(any_word());
        end
    endfunction

    task automatic directed_line(input string txt, input bit end_on_char);
        line_bytes.delete();
        push_text(txt);
        send_line(end_on_char);
    endtask

    initial begin
        int lines;
        board        = new();
        items_sent   = 0;
        quiet_cycles = 0;
        calm_tail    = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines: value limits of the pressure, every command, the
        // malformed forms, and the white space, zero byte and overlong cases.
        directed_line("SENSE PRESS 0", 1'b1);
        directed_line("SENSE PRESS 120", 1'b0);
        directed_line("SENSE PRESS 121", 1'b1);
        directed_line("SENSE PRESS -0", 1'b1);
        directed_line("SENSE PRESS -5", 1'b0);
        directed_line("SENSE PRESS +7", 1'b1);
        directed_line("SENSE PRESS 99999", 1'b1);
        directed_line("SENSE PRESS", 1'b1);
        directed_line("SENSE PRESS 5 EXTRA", 1'b1);
        directed_line("SENSE PRESS \r12", 1'b1);
        directed_line("\t SENSE  PRESS\t 42 \r\n", 1'b0);
        directed_line("SENSE DOOR OPEN", 1'b1);
        directed_line("SENSE DOOR CLOSED", 1'b0);
        directed_line("SENSE DOOR AJAR", 1'b1);
        directed_line({"FAULT ", TIMEOUT_WORD}, 1'b1);
        directed_line("sense press 5", 1'b1);
        directed_line("\377\200 SENSE\177", 1'b1);
        // Empty line, then a blank one.
        directed_line("", 1'b0);
        directed_line(" \t\v\f\r ", 1'b1);
        // A zero byte hides everything after it.
        line_bytes.delete();
        push_text("FAULT ");
        push_text(TIMEOUT_WORD);
        line_bytes.push_back(CH_NUL);
        push_text(" JUNK");
        send_line(1'b1);
        // Bytes past the capacity are dropped: the words after the padding are lost
        // in the first line, and all text is lost behind leading blanks in the second.
        line_bytes.delete();
        push_text("SENSE DOOR OPEN");
        push_blanks(50);
        push_text("CLOSED X");
        send_line(1'b1);
        line_bytes.delete();
        push_blanks(70);
        push_text("FAULT ");
        push_text(TIMEOUT_WORD);
        send_line(1'b0);
        wait_all_answered();

        // Random lines until the item budget is spent; the sender waits for
        // all answers a few times along the way.
        lines = 0;
        while (items_sent < ITEM_TARGET) begin
            calm_tail = (items_sent > CALM_FROM);
            build_random_line();
            send_line($urandom_range(0, 1));
            lines++;
            if (lines % 60 == 30) begin
                wait_all_answered();
            end
        end
        i_in_valid <= 1'b0;

        // Wait for the last answers; the watchdog ends a hung run.
        do @(negedge i_clk); while (board.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> sensor_command_line_parser_unit.f
sv/scl_pkg.sv
sv/scl_classify.sv
sv/sensor_command_line_parser_unit.sv
verif/tb_sensor_command_line_parser_unit.sv
